@@ hdl/stfs_pkg.sv @@
// Package for the sorted time floor search unit.
// Holds command and status codes, controller states and fixed field widths.
// No dependencies.
package stfs_pkg;

  // Widths of the fields that do not follow from a module parameter.
  localparam int unsigned CMD_W    = 2;
  localparam int unsigned TIME_W   = 64;
  localparam int unsigned STATUS_W = 3;

  typedef enum logic [CMD_W-1:0] {
    CMD_CLEAR  = 2'd0,
    CMD_APPEND = 2'd1,
    CMD_QUERY  = 2'd2
  } cmd_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK     = 3'd0,
    ST_BEFORE = 3'd1,
    ST_EMPTY  = 3'd2,
    ST_FULL   = 3'd3,
    ST_ORDER  = 3'd4
  } status_e;

  typedef enum logic [1:0] {
    S_IDLE,
    S_LAUNCH,
    S_PROBE,
    S_KEY
  } state_e;

endpackage

@@ hdl/stfs_ram.sv @@
// Simple dual-port synchronous RAM holding the sample time table.
// One write port and one read port with registered read data.
// No dependencies.
module stfs_ram #(
  parameter int unsigned DEPTH = 1024,
  parameter int unsigned WIDTH = 64,
  parameter int unsigned AW    = 10
) (
  input  logic             clk_i,
  input  logic             wr_en_i,
  input  logic [AW-1:0]    wr_addr_i,
  input  logic [WIDTH-1:0] wr_data_i,
  input  logic             rd_en_i,
  input  logic [AW-1:0]    rd_addr_i,
  output logic [WIDTH-1:0] rd_data_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_q <= mem[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

@@ hdl/sorted_time_floor_search_unit.sv @@
// Top level of the sorted time floor search unit.
// Depends on stfs_pkg and stfs_ram.
//
// A transaction starts when start is high while busy is low. Clear, append and unused
// commands finish at once: the result strobe comes in the cycle after start and a new
// transaction may be issued in that same cycle. A query on a non-empty table runs a binary
// search over the held entries, one table read per cycle through the single read port of
// the table memory, so a search over n entries probes about ceil(log2(n+1)) entries. With
// pick_last set, or when the query falls before all entries, the result strobe follows that
// one search; picking the first of equal times fetches the floor entry's time as the key and
// runs a second search over the entries up to the floor for the first entry equal to it.
// Results cannot be held off: each result is shown for one cycle on result_valid_o.
module sorted_time_floor_search_unit #(
  parameter int unsigned TABLE_DEPTH = 1024,
  parameter int unsigned TIME_BITS   = 64
) (
  input  logic                                          clk_i,
  input  logic                                          rst_ni,
  input  logic                                          start,
  output logic                                          busy,
  input  logic [stfs_pkg::CMD_W-1:0]                    cmd_i,
  input  logic [stfs_pkg::TIME_W-1:0]                   time_value_i,
  input  logic                                          pick_last_i,
  output logic                                          result_valid_o,
  output logic [stfs_pkg::STATUS_W-1:0]                 status_o,
  output logic [$clog2(TABLE_DEPTH)-1:0]                index_o,
  output logic [$clog2(TABLE_DEPTH+1)-1:0]              entry_count_o
);

  import stfs_pkg::*;

  localparam int unsigned AW = $clog2(TABLE_DEPTH);
  localparam int unsigned CW = $clog2(TABLE_DEPTH + 1);

  function automatic logic [CW-1:0] mid_of(input logic [CW-1:0] lo, input logic [CW-1:0] hi);
    logic [CW-1:0] span;
    span = hi - lo;
    return lo + (span >> 1);
  endfunction

  state_e                state_q, state_d;
  logic [CW-1:0]         count_q, count_d;
  logic [TIME_BITS-1:0]  last_q, last_d;
  logic [TIME_BITS-1:0]  target_q, target_d;
  logic                  pick_last_q, pick_last_d;
  logic                  mode_q, mode_d;      // Set for the search of the first equal time.
  logic [CW-1:0]         lo_q, lo_d, hi_q, hi_d, mid_q, mid_d;
  logic                  res_valid_q, res_valid_d;
  status_e               status_q, status_d;
  logic [AW-1:0]         index_q, index_d;
  logic [CW-1:0]         ecount_q, ecount_d;

  logic                  wr_en, rd_en;
  logic [AW-1:0]         wr_addr, rd_addr;
  logic [TIME_BITS-1:0]  wr_data, rd_data;

  logic                  go_right, cont;
  logic [CW-1:0]         lo_upd, hi_upd, mid_nxt, mid_launch;
  logic                  accept;

  // Writes happen only in the idle state and reads only during a search, so a read
  // never meets a write to the same entry in flight.
  stfs_ram #(
    .DEPTH (TABLE_DEPTH),
    .WIDTH (TIME_BITS),
    .AW    (AW)
  ) u_ram (
    .clk_i     (clk_i),
    .wr_en_i   (wr_en),
    .wr_addr_i (wr_addr),
    .wr_data_i (wr_data),
    .rd_en_i   (rd_en),
    .rd_addr_i (rd_addr),
    .rd_data_o (rd_data)
  );

  assign busy   = (state_q != S_IDLE);
  assign accept = start && !busy;

  // One search step: the entry read at mid_q is back and narrows the range.
  always_comb begin
    go_right   = mode_q ? (rd_data < target_q) : (rd_data <= target_q);
    lo_upd     = go_right ? (mid_q + CW'(1)) : lo_q;
    hi_upd     = go_right ? hi_q : mid_q;
    cont       = (lo_upd < hi_upd);
    mid_nxt    = mid_of(lo_upd, hi_upd);
    mid_launch = mid_of(lo_q, hi_q);
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (accept && (cmd_i == CMD_QUERY) && (count_q != '0)) begin
          state_d = S_LAUNCH;
        end
      end
      S_LAUNCH: state_d = S_PROBE;
      S_PROBE: begin
        if (cont) begin
          state_d = S_PROBE;
        end else if (mode_q || (lo_upd == '0) || pick_last_q) begin
          state_d = S_IDLE;
        end else begin
          state_d = S_KEY;
        end
      end
      S_KEY:   state_d = S_LAUNCH;
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    count_d     = count_q;
    last_d      = last_q;
    target_d    = target_q;
    pick_last_d = pick_last_q;
    mode_d      = mode_q;
    lo_d        = lo_q;
    hi_d        = hi_q;
    mid_d       = mid_q;
    res_valid_d = 1'b0;
    status_d    = status_q;
    index_d     = index_q;
    ecount_d    = ecount_q;
    wr_en       = 1'b0;
    wr_addr     = count_q[AW-1:0];
    wr_data     = time_value_i[TIME_BITS-1:0];
    rd_en       = 1'b0;
    rd_addr     = mid_launch[AW-1:0];

    case (state_q)
      S_IDLE: begin
        if (accept) begin
          target_d    = time_value_i[TIME_BITS-1:0];
          pick_last_d = pick_last_i;
          mode_d      = 1'b0;
          lo_d        = '0;
          hi_d        = count_q;
          index_d     = '0;
          status_d    = ST_OK;
          ecount_d    = count_q;
          case (cmd_i)
            CMD_CLEAR: begin
              count_d     = '0;
              ecount_d    = '0;
              res_valid_d = 1'b1;
            end
            CMD_APPEND: begin
              res_valid_d = 1'b1;
              if (count_q == CW'(TABLE_DEPTH)) begin
                status_d = ST_FULL;
              end else if ((count_q != '0) && (time_value_i[TIME_BITS-1:0] < last_q)) begin
                status_d = ST_ORDER;
              end else begin
                wr_en    = 1'b1;
                last_d   = time_value_i[TIME_BITS-1:0];
                count_d  = count_q + CW'(1);
                ecount_d = count_q + CW'(1);
              end
            end
            CMD_QUERY: begin
              if (count_q == '0) begin
                status_d    = ST_EMPTY;
                res_valid_d = 1'b1;
              end
            end
            default: begin
              res_valid_d = 1'b1;
            end
          endcase
        end
      end
      S_LAUNCH: begin
        rd_en   = 1'b1;
        rd_addr = mid_launch[AW-1:0];
        mid_d   = mid_launch;
      end
      S_PROBE: begin
        lo_d = lo_upd;
        hi_d = hi_upd;
        if (cont) begin
          rd_en   = 1'b1;
          rd_addr = mid_nxt[AW-1:0];
          mid_d   = mid_nxt;
        end else if (mode_q) begin
          res_valid_d = 1'b1;
          status_d    = ST_OK;
          index_d     = lo_upd[AW-1:0];
        end else if (lo_upd == '0) begin
          res_valid_d = 1'b1;
          status_d    = ST_BEFORE;
          index_d     = '0;
        end else if (pick_last_q) begin
          res_valid_d = 1'b1;
          status_d    = ST_OK;
          index_d     = AW'(lo_upd - CW'(1));
        end else begin
          // Fetch the floor entry's time; the second search finds its first occurrence.
          rd_en   = 1'b1;
          rd_addr = AW'(lo_upd - CW'(1));
          lo_d    = '0;
          hi_d    = lo_upd;
        end
      end
      S_KEY: begin
        target_d = rd_data;
        mode_d   = 1'b1;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      count_q     <= '0;
      res_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      res_valid_q <= res_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    last_q      <= last_d;
    target_q    <= target_d;
    pick_last_q <= pick_last_d;
    mode_q      <= mode_d;
    lo_q        <= lo_d;
    hi_q        <= hi_d;
    mid_q       <= mid_d;
    status_q    <= status_d;
    index_q     <= index_d;
    ecount_q    <= ecount_d;
  end

  assign result_valid_o = res_valid_q;
  assign status_o       = status_q;
  assign index_o        = index_q;
  assign entry_count_o  = ecount_q;

endmodule

@@ hdl/stfs_checker.sv @@
// Port-level checker for the sorted time floor search unit, bound to the top level.
// Depends on stfs_pkg and sorted_time_floor_search_unit.
module stfs_checker #(
  parameter int unsigned TABLE_DEPTH = 1024
) (
  input logic                                  clk_i,
  input logic                                  rst_ni,
  input logic                                  start,
  input logic                                  busy,
  input logic [stfs_pkg::CMD_W-1:0]            cmd_i,
  input logic                                  result_valid_o,
  input logic [stfs_pkg::STATUS_W-1:0]         status_o,
  input logic [$clog2(TABLE_DEPTH)-1:0]        index_o,
  input logic [$clog2(TABLE_DEPTH+1)-1:0]      entry_count_o
);

  import stfs_pkg::*;

  // A result is only ever delivered once the unit is free again.
  a_result_when_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> !busy)
    else $error("result delivered while busy");

  a_status_legal: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> (status_o == ST_OK || status_o == ST_BEFORE || status_o == ST_EMPTY ||
                        status_o == ST_FULL || status_o == ST_ORDER))
    else $error("result carries an unknown status");

  a_index_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_o && status_o != ST_OK) |-> (index_o == '0))
    else $error("failed transaction reports a non-zero index");

  a_clear_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy && cmd_i == CMD_CLEAR) |=>
      (result_valid_o && status_o == ST_OK && entry_count_o == '0))
    else $error("clear did not answer with an empty table");

  a_append_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy && cmd_i == CMD_APPEND) |=> (result_valid_o && !busy))
    else $error("append did not answer in the next cycle");

endmodule

bind sorted_time_floor_search_unit stfs_checker #(
  .TABLE_DEPTH (TABLE_DEPTH)
) u_stfs_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .start          (start),
  .busy           (busy),
  .cmd_i          (cmd_i),
  .result_valid_o (result_valid_o),
  .status_o       (status_o),
  .index_o        (index_o),
  .entry_count_o  (entry_count_o)
);

@@ verif/sorted_time_floor_search_unit_tb.sv @@
// Self-checking testbench for the sorted time floor search unit.
// Depends on stfs_pkg and the unit's RTL; a behavioural table model predicts every result.
// Covers directed corner cases, a full table and a random mix of clears, appends and queries.
module sorted_time_floor_search_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import stfs_pkg::*;

  localparam int unsigned DEPTH = 1024;
  localparam int unsigned IDX_W = $clog2(DEPTH);
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);
  localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;
  localparam logic [TIME_W-1:0] TIME_MAX = '1;

  typedef struct packed {
    status_e          status;
    logic [IDX_W-1:0] index;
    logic [CNT_W-1:0] count;
  } outcome_t;

  logic clk_i = 1'b0;
  logic rst_ni;
  logic start;
  logic busy;
  logic [CMD_W-1:0] cmd_i;
  logic [TIME_W-1:0] time_value_i;
  logic pick_last_i;
  logic result_valid_o;
  logic [STATUS_W-1:0] status_o;
  logic [IDX_W-1:0] index_o;
  logic [CNT_W-1:0] entry_count_o;

  // Shadow of the table contents and the expected results still in flight.
  logic [TIME_W-1:0] stored_times [DEPTH];
  int unsigned stored_count = 0;
  outcome_t expected_outcomes [$];

  int unsigned errors = 0;
  int unsigned sent_count = 0;
  int unsigned checked_count = 0;
  int unsigned query_count = 0;
  int unsigned pick_last_count = 0;
  int unsigned largest_table = 0;
  int unsigned status_seen [5];
  bit steady = 1'b0;

  sorted_time_floor_search_unit #(
    .TABLE_DEPTH(DEPTH),
    .TIME_BITS  (TIME_W)
  ) dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start         (start),
    .busy          (busy),
    .cmd_i         (cmd_i),
    .time_value_i  (time_value_i),
    .pick_last_i   (pick_last_i),
    .result_valid_o(result_valid_o),
    .status_o      (status_o),
    .index_o       (index_o),
    .entry_count_o (entry_count_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Applies one transaction to the shadow table and returns the result it should produce.
  function automatic outcome_t predict_outcome(input logic [CMD_W-1:0] op,
                                               input logic [TIME_W-1:0] t,
                                               input logic pick_last);
    outcome_t o;
    int unsigned lo, hi, mid;
    logic [TIME_W-1:0] key;
    o.status = ST_OK;
    o.index  = '0;
    case (op)
      CMD_CLEAR: stored_count = 0;
      CMD_APPEND: begin
        if (stored_count >= DEPTH) begin
          o.status = ST_FULL;
        end else if (stored_count > 0 && t < stored_times[stored_count-1]) begin
          o.status = ST_ORDER;
        end else begin
          stored_times[stored_count] = t;
          stored_count++;
        end
      end
      CMD_QUERY: begin
        if (stored_count == 0) begin
          o.status = ST_EMPTY;
        end else begin
          // Upper bound: number of entries at or before the target.
          lo = 0;
          hi = stored_count;
          while (lo < hi) begin
            mid = (lo + hi) / 2;
            if (stored_times[mid] <= t) lo = mid + 1;
            else hi = mid;
          end
          if (lo == 0) begin
            o.status = ST_BEFORE;
          end else if (pick_last) begin
            o.index = IDX_W'(lo - 1);
          end else begin
            // Walk back to the first of the run of equal times.
            key = stored_times[lo-1];
            hi  = lo - 1;
            lo  = 0;
            while (lo < hi) begin
              mid = (lo + hi) / 2;
              if (stored_times[mid] < key) lo = mid + 1;
              else hi = mid;
            end
            o.index = IDX_W'(lo);
          end
        end
      end
      default: ;
    endcase
    o.count = CNT_W'(stored_count);
    return o;
  endfunction

  function automatic int unsigned random_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (steady || r < 45) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(11, 40);
  endfunction

  // A well-formed append time: the last entry plus a step that often repeats it.
  function automatic logic [TIME_W-1:0] next_time();
    logic [TIME_W-1:0] last, step;
    int unsigned r;
    if (stored_count == 0) return {$urandom, $urandom} >> $urandom_range(0, 63);
    last = stored_times[stored_count-1];
    r = $urandom_range(0, 99);
    if (r < 30) step = '0;
    else if (r < 70) step = TIME_W'($urandom_range(1, 4));
    else if (r < 95) step = TIME_W'($urandom_range(1, 1 << 20));
    else step = {$urandom, $urandom} >> $urandom_range(16, 63);
    if (last + step < last) return last;
    return last + step;
  endfunction

  function automatic logic [TIME_W-1:0] early_time();
    logic [TIME_W-1:0] last, step;
    if (stored_count == 0) return {$urandom, $urandom};
    last = stored_times[stored_count-1];
    step = TIME_W'($urandom_range(1, 1000));
    return (last > step) ? last - step : '0;
  endfunction

  // Query targets cluster on held times and their neighbours.
  function automatic logic [TIME_W-1:0] query_target();
    logic [TIME_W-1:0] e;
    int unsigned r;
    r = $urandom_range(0, 99);
    if (stored_count == 0 || r < 10) return {$urandom, $urandom};
    e = stored_times[$urandom_range(0, stored_count - 1)];
    if (r < 50) return e;
    if (r < 65) return e - 1;
    if (r < 80) return e + 1;
    if (r < 90) return e + TIME_W'($urandom_range(0, 1000));
    if (r < 95) return '0;
    return TIME_MAX;
  endfunction

  task automatic pause_sender(input int unsigned cycles);
    if (cycles == 0) return;
    @(negedge clk_i);
    start        <= 1'b0;
    cmd_i        <= CMD_W'($urandom);
    time_value_i <= {$urandom, $urandom};
    pick_last_i  <= 1'($urandom);
    repeat (cycles - 1) @(negedge clk_i);
  endtask

  task automatic issue(input logic [CMD_W-1:0] op, input logic [TIME_W-1:0] t,
                       input logic pl);
    pause_sender(random_gap());
    @(negedge clk_i);
    start        <= 1'b1;
    cmd_i        <= op;
    time_value_i <= t;
    pick_last_i  <= pl;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
    expected_outcomes.push_back(predict_outcome(op, t, pl));
    sent_count++;
    if (op == CMD_QUERY) begin
      query_count++;
      if (pl) pick_last_count++;
    end
    if (stored_count > largest_table) largest_table = stored_count;
  endtask

  task automatic wait_for_results();
    @(negedge clk_i);
    start <= 1'b0;
    while (expected_outcomes.size() != 0) @(posedge clk_i);
  endtask

  always @(posedge clk_i) begin : check_results
    outcome_t want;
    if (rst_ni && result_valid_o) begin
      if (expected_outcomes.size() == 0) begin
        $display("%0t: result with none expected: status %0d index %0d count %0d",
                 $realtime, status_o, index_o, entry_count_o);
        errors++;
      end else begin
        want = expected_outcomes.pop_front();
        checked_count++;
        status_seen[want.status]++;
        if (status_o !== want.status) begin
          $display("%0t: status mismatch, expected %0d, actual %0d",
                   $realtime, want.status, status_o);
          errors++;
        end
        if (index_o !== want.index) begin
          $display("%0t: index mismatch, expected %0d, actual %0d",
                   $realtime, want.index, index_o);
          errors++;
        end
        if (entry_count_o !== want.count) begin
          $display("%0t: entry_count mismatch, expected %0d, actual %0d",
                   $realtime, want.count, entry_count_o);
          errors++;
        end
      end
    end
  end

  task automatic test_directed();
    issue(CMD_QUERY, '0, 1'b0);
    issue(CMD_QUERY, TIME_MAX, 1'b1);
    issue(CMD_UNUSED, {$urandom, $urandom}, 1'b0);
    issue(CMD_APPEND, 64'd100, 1'b1);
    issue(CMD_APPEND, 64'd100, 1'b0);
    issue(CMD_APPEND, 64'd100, 1'b0);
    issue(CMD_APPEND, 64'd99, 1'b0);
    issue(CMD_APPEND, 64'd200, 1'b0);
    issue(CMD_QUERY, 64'd99, 1'b1);
    issue(CMD_QUERY, 64'd100, 1'b0);
    issue(CMD_QUERY, 64'd100, 1'b1);
    issue(CMD_QUERY, 64'd150, 1'b0);
    issue(CMD_QUERY, 64'd200, 1'b1);
    issue(CMD_QUERY, TIME_MAX, 1'b0);
    issue(CMD_QUERY, '0, 1'b0);
    issue(CMD_APPEND, TIME_MAX, 1'b0);
    issue(CMD_APPEND, TIME_MAX, 1'b0);
    issue(CMD_QUERY, TIME_MAX, 1'b0);
    issue(CMD_QUERY, TIME_MAX, 1'b1);
    issue(CMD_APPEND, '0, 1'b0);
    issue(CMD_UNUSED, '0, 1'b1);
    issue(CMD_CLEAR, {$urandom, $urandom}, 1'b1);
    issue(CMD_QUERY, '0, 1'b1);
    issue(CMD_APPEND, '0, 1'b0);
    issue(CMD_QUERY, TIME_MAX, 1'b0);
    wait_for_results();
  endtask

  // Fills the table to its last entry, checks refused appends and searches the full range.
  task automatic test_full_table();
    issue(CMD_CLEAR, '0, 1'b0);
    repeat (DEPTH) begin
      if ($urandom_range(0, 63) == 0) steady = !steady;
      issue(CMD_APPEND, next_time(), 1'($urandom));
    end
    steady = 1'b0;
    issue(CMD_APPEND, next_time(), 1'b0);
    issue(CMD_APPEND, '0, 1'b1);
    wait_for_results();
    repeat (200) issue(CMD_QUERY, query_target(), 1'($urandom));
    wait_for_results();
  endtask

  // Mostly well-formed appends and targeted queries, with clears, refused appends and noise.
  task automatic test_random_mix();
    int unsigned r;
    for (int i = 0; i < 600; i++) begin
      if ($urandom_range(0, 49) == 0) steady = !steady;
      if (i % 150 == 149) wait_for_results();
      r = $urandom_range(0, 99);
      if (r < 3) issue(CMD_CLEAR, {$urandom, $urandom}, 1'($urandom));
      else if (r < 8) issue(CMD_W'($urandom), {$urandom, $urandom}, 1'($urandom));
      else if (r < 13) issue(CMD_APPEND, early_time(), 1'($urandom));
      else if (r < 48) issue(CMD_APPEND, next_time(), 1'($urandom));
      else issue(CMD_QUERY, query_target(), 1'($urandom));
    end
    steady = 1'b0;
    wait_for_results();
  endtask

  initial begin
    rst_ni       = 1'b0;
    start        = 1'b0;
    cmd_i        = CMD_CLEAR;
    time_value_i = '0;
    pick_last_i  = 1'b0;
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    test_directed();
    test_full_table();
    test_random_mix();

    repeat (40) @(posedge clk_i);
    $display("Sent %0d transactions, checked %0d results (%0d queries, %0d picking the last).",
             sent_count, checked_count, query_count, pick_last_count);
    $display("Status ok %0d, before all %0d, empty %0d, full %0d, out of order %0d; table peak %0d.",
             status_seen[ST_OK], status_seen[ST_BEFORE], status_seen[ST_EMPTY],
             status_seen[ST_FULL], status_seen[ST_ORDER], largest_table);
    if (errors == 0) begin
      $display("sorted_time_floor_search_unit_tb OK");
    end else begin
      $display("sorted_time_floor_search_unit_tb NOT OK");
    end
    $finish;
  end

  initial begin
    #20_000_000;
    $display("sorted_time_floor_search_unit_tb NOT OK");
    $finish;
  end

endmodule
